>>> rtl/core/sem_pkg.sv
// ----------------------------------------------------------------------------
// sem_pkg
// Shared types and constants of the Sobel edge magnitude unit.
// ----------------------------------------------------------------------------
package sem_pkg;

	localparam int DEF_MAX_WIDTH  = 2048;
	localparam int DEF_MAX_HEIGHT = 4096;

	localparam int PIX_W      = 8;
	localparam int LW_W       = 12;
	localparam int FH_W       = 13;
	localparam int THR_W      = 8;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 2;

	localparam logic [LW_W-1:0]  LW_RESET  = 12'd640;
	localparam logic [FH_W-1:0]  FH_RESET  = 13'd480;
	localparam logic [THR_W-1:0] THR_RESET = 8'd50;

	// Smallest legal frame dimension.
	localparam int MIN_DIM = 3;

	// Square root of a 16-bit value, one result bit per step.
	localparam int ROOT_STEPS = 8;
	localparam int ROOT_CNT_W = $clog2(ROOT_STEPS);
	localparam int ROOT_V_W   = 2 * ROOT_STEPS;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LINE_WIDTH     = 2'd0,
		REG_FRAME_HEIGHT   = 2'd1,
		REG_EDGE_THRESHOLD = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_SQUARE,
		ST_ROOT,
		ST_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic accept;
		logic calc;
		logic square;
		logic root_step;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_status_t;

endpackage

>>> rtl/core/sem_stream_if.sv
// ----------------------------------------------------------------------------
// sem_stream_if
// Valid/ready channels for the pixel input and the result output.
// ----------------------------------------------------------------------------
interface sem_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] gray_pixel;

	modport source (output valid, output gray_pixel, input ready);
	modport sink   (input valid, input gray_pixel, output ready);
endinterface

interface sem_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] magnitude;
	logic       edge_res;
	logic       interior;
	logic       end_of_frame;

	modport source (output valid, output magnitude, output edge_res, output interior,
		output end_of_frame, input ready);
	modport sink   (input valid, input magnitude, input edge_res, input interior,
		input end_of_frame, output ready);
endinterface

>>> rtl/core/sobel_edge_magnitude_3x3_unit.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_3x3_unit
// Streams 8-bit gray pixels in raster order and returns, for each pixel, the
// clamped Sobel magnitude and edge flag of the centre one row and one column
// back. Each pixel passes through the transfer cycle, which reads the row
// stores, the gradient state, the square state and the square root steps,
// which yield one result bit per cycle, and a last state that loads the
// result into the output register. The next pixel can be taken in the cycle
// after that load, so no pixel is taken while one is still in work. A waiting
// result holds the unit only in that last state. Border centres report
// interior low and magnitude zero. The two row stores need no clearing after
// reset, and frame size and threshold take effect at once when written.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_3x3_unit #(
	parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [sem_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sem_pkg::CFG_DATA_W-1:0] cfg_data,
	sem_pixel_if.sink                      pixel,
	sem_result_if.source                   result
);
	import sem_pkg::*;

	localparam int WCW = ($clog2(MAX_WIDTH + 1) > LW_W) ? $clog2(MAX_WIDTH + 1) : LW_W;
	localparam int HCW = ($clog2(MAX_HEIGHT + 1) > FH_W) ? $clog2(MAX_HEIGHT + 1) : FH_W;

	logic [WCW-1:0]   width_used;
	logic [HCW-1:0]   height_used;
	logic [THR_W-1:0] threshold;
	dp_cmd_t          cmd;
	dp_status_t       status;

	sem_cfg_regs #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.WCW        (WCW),
		.HCW        (HCW)
	) u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.width_used  (width_used),
		.height_used (height_used),
		.threshold   (threshold)
	);

	sem_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pixel.valid),
		.pix_ready (pixel.ready),
		.status    (status),
		.cmd       (cmd)
	);

	sem_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.WCW        (WCW),
		.HCW        (HCW)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.gray_pixel   (pixel.gray_pixel),
		.width_used   (width_used),
		.height_used  (height_used),
		.threshold    (threshold),
		.res_valid    (result.valid),
		.res_ready    (result.ready),
		.magnitude    (result.magnitude),
		.edge_res     (result.edge_res),
		.interior     (result.interior),
		.end_of_frame (result.end_of_frame)
	);

endmodule

>>> rtl/core/sem_cfg_regs.sv
// ----------------------------------------------------------------------------
// sem_cfg_regs
// Configuration registers with saturation of the frame size to legal values.
// ----------------------------------------------------------------------------
module sem_cfg_regs #(
	parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT,
	parameter int WCW        = $clog2(MAX_WIDTH + 1),
	parameter int HCW        = $clog2(MAX_HEIGHT + 1)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [sem_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sem_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic [WCW-1:0]                   width_used,
	output logic [HCW-1:0]                   height_used,
	output logic [sem_pkg::THR_W-1:0]        threshold
);
	import sem_pkg::*;

	logic [LW_W-1:0]  line_width_q;
	logic [FH_W-1:0]  frame_height_q;
	logic [THR_W-1:0] threshold_q;
	logic [WCW-1:0]   lw_ext;
	logic [HCW-1:0]   fh_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q   <= LW_RESET;
			frame_height_q <= FH_RESET;
			threshold_q    <= THR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LINE_WIDTH:     line_width_q   <= cfg_data[LW_W-1:0];
				REG_FRAME_HEIGHT:   frame_height_q <= cfg_data[FH_W-1:0];
				REG_EDGE_THRESHOLD: threshold_q    <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	assign lw_ext = WCW'(line_width_q);
	assign fh_ext = HCW'(frame_height_q);

	always_comb begin
		if (line_width_q < LW_W'(MIN_DIM)) begin
			width_used = WCW'(MIN_DIM);
		end else if (WCW > LW_W || lw_ext > WCW'(MAX_WIDTH)) begin
			width_used = (lw_ext > WCW'(MAX_WIDTH)) ? WCW'(MAX_WIDTH) : lw_ext;
		end else begin
			width_used = lw_ext;
		end
		if (frame_height_q < FH_W'(MIN_DIM)) begin
			height_used = HCW'(MIN_DIM);
		end else if (fh_ext > HCW'(MAX_HEIGHT)) begin
			height_used = HCW'(MAX_HEIGHT);
		end else begin
			height_used = fh_ext;
		end
	end

	assign threshold = threshold_q;

endmodule

>>> rtl/core/sem_ctrl.sv
// ----------------------------------------------------------------------------
// sem_ctrl
// Sequencer for one pixel: window read, gradient, squares, root steps, result.
// ----------------------------------------------------------------------------
module sem_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pix_valid,
	output logic                pix_ready,
	input  sem_pkg::dp_status_t status,
	output sem_pkg::dp_cmd_t    cmd
);
	import sem_pkg::*;

	ctrl_state_t           state_q;
	ctrl_state_t           state_next;
	logic [ROOT_CNT_W-1:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_next;
			step_q  <= (state_q == ST_ROOT) ? step_q + ROOT_CNT_W'(1) : '0;
		end
	end

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		pix_ready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				pix_ready = 1'b1;
				if (pix_valid) begin
					cmd.accept = 1'b1;
					state_next = ST_CALC;
				end
			end
			ST_CALC: begin
				cmd.calc   = 1'b1;
				state_next = ST_SQUARE;
			end
			ST_SQUARE: begin
				cmd.square = 1'b1;
				state_next = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.root_step = 1'b1;
				if (step_q == ROOT_CNT_W'(ROOT_STEPS - 1)) begin
					state_next = ST_DONE;
				end
			end
			ST_DONE: begin
				// Hold the finished result until the output register is free.
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_next   = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

endmodule

>>> rtl/core/sem_datapath.sv
// ----------------------------------------------------------------------------
// sem_datapath
// Row stores, window taps, position counters, gradient, square root and the
// result register.
// ----------------------------------------------------------------------------
module sem_datapath #(
	parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT,
	parameter int WCW        = $clog2(MAX_WIDTH + 1),
	parameter int HCW        = $clog2(MAX_HEIGHT + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sem_pkg::dp_cmd_t            cmd,
	output sem_pkg::dp_status_t         status,
	input  logic [sem_pkg::PIX_W-1:0]   gray_pixel,
	input  logic [WCW-1:0]              width_used,
	input  logic [HCW-1:0]              height_used,
	input  logic [sem_pkg::THR_W-1:0]   threshold,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic [sem_pkg::PIX_W-1:0]   magnitude,
	output logic                        edge_res,
	output logic                        interior,
	output logic                        end_of_frame
);
	import sem_pkg::*;

	localparam int CIW = $clog2(MAX_WIDTH);
	localparam int RIW = $clog2(MAX_HEIGHT);

	logic [PIX_W-1:0] older_mem [MAX_WIDTH];
	logic [PIX_W-1:0] newer_mem [MAX_WIDTH];

	logic [PIX_W-1:0] pix_s1;
	logic [PIX_W-1:0] top_s1;
	logic [PIX_W-1:0] mid_s1;
	logic [PIX_W-1:0] taps_q [6];
	logic [CIW-1:0]   col_q;
	logic [RIW-1:0]   row_q;

	logic signed [10:0] gx_s2;
	logic signed [10:0] gy_s2;
	logic               interior_s2;
	logic               eof_s2;

	logic [ROOT_V_W-1:0] v_q;
	logic [ROOT_V_W-1:0] root_q;
	logic [ROOT_V_W-1:0] bit_q;
	logic                sat_q;

	logic                res_valid_q;
	logic [PIX_W-1:0]    mag_q;
	logic                edge_q;
	logic                interior_q;
	logic                eof_q;

	// Gradient and position logic for the calc step.
	logic [9:0]         gx_pos, gx_neg, gy_pos, gy_neg;
	logic signed [10:0] gx, gy;
	logic [WCW-1:0]     col_ext, col_inc;
	logic [HCW-1:0]     row_ext, row_inc;
	logic               col_wrap, row_wrap, in_frame;

	// Squares and root step.
	logic signed [21:0]  gx_sq, gy_sq;
	logic [20:0]         sum;
	logic [ROOT_V_W:0]   trial;
	logic [PIX_W-1:0]    mag_final;

	// Both stores are read at the column of the pixel being accepted.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pix_s1 <= gray_pixel;
			top_s1 <= older_mem[col_q];
			mid_s1 <= newer_mem[col_q];
		end
		if (cmd.calc) begin
			older_mem[col_q] <= mid_s1;
			newer_mem[col_q] <= pix_s1;
		end
	end

	always_comb begin
		gx_pos  = 10'(top_s1) + {1'b0, mid_s1, 1'b0} + 10'(pix_s1);
		gx_neg  = 10'(taps_q[0]) + {1'b0, taps_q[1], 1'b0} + 10'(taps_q[2]);
		gy_pos  = 10'(taps_q[2]) + {1'b0, taps_q[5], 1'b0} + 10'(pix_s1);
		gy_neg  = 10'(taps_q[0]) + {1'b0, taps_q[3], 1'b0} + 10'(top_s1);
		gx      = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
		gy      = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
		col_ext = WCW'(col_q);
		row_ext = HCW'(row_q);
		col_inc = col_ext + WCW'(1);
		row_inc = row_ext + HCW'(1);
		col_wrap = col_inc >= width_used;
		row_wrap = row_inc >= height_used;
		in_frame = (row_q >= RIW'(2)) && (col_q >= CIW'(2))
			&& (col_ext < width_used) && (row_ext < height_used);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			for (int i = 0; i < 6; i++) begin
				taps_q[i] <= '0;
			end
		end else if (cmd.calc) begin
			taps_q[0] <= taps_q[3];
			taps_q[1] <= taps_q[4];
			taps_q[2] <= taps_q[5];
			taps_q[3] <= top_s1;
			taps_q[4] <= mid_s1;
			taps_q[5] <= pix_s1;
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_inc[RIW-1:0];
			end else begin
				col_q <= col_inc[CIW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			gx_s2       <= gx;
			gy_s2       <= gy;
			interior_s2 <= in_frame;
			eof_s2      <= col_wrap && row_wrap;
		end
	end

	always_comb begin
		gx_sq = gx_s2 * gx_s2;
		gy_sq = gy_s2 * gy_s2;
		sum   = {1'b0, gx_sq[19:0]} + {1'b0, gy_sq[19:0]};
		trial = {1'b0, root_q} + {1'b0, bit_q};
	end

	// Sums of 2^16 and above give a root beyond 255 and saturate directly.
	always_ff @(posedge clk) begin
		if (cmd.square) begin
			v_q    <= sum[ROOT_V_W-1:0];
			sat_q  <= |sum[20:ROOT_V_W];
			root_q <= '0;
			bit_q  <= ROOT_V_W'(1) << (ROOT_V_W - 2);
		end else if (cmd.root_step) begin
			if ({1'b0, v_q} >= trial) begin
				v_q    <= v_q - trial[ROOT_V_W-1:0];
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	always_comb begin
		if (!interior_s2) begin
			mag_final = '0;
		end else if (sat_q) begin
			mag_final = '1;
		end else begin
			mag_final = root_q[PIX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			mag_q      <= mag_final;
			edge_q     <= mag_final > threshold;
			interior_q <= interior_s2;
			eof_q      <= eof_s2;
		end
	end

	assign status.out_free = !res_valid_q || res_ready;
	assign res_valid       = res_valid_q;
	assign magnitude       = mag_q;
	assign edge_res        = edge_q;
	assign interior        = interior_q;
	assign end_of_frame    = eof_q;

endmodule

>>> rtl/core/sem_checker.sv
// ----------------------------------------------------------------------------
// sem_checker
// Port-level checks of the Sobel edge magnitude unit, bound to the top level.
// ----------------------------------------------------------------------------
module sem_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       pix_valid,
	input logic       pix_ready,
	input logic       res_valid,
	input logic       res_ready,
	input logic [7:0] magnitude,
	input logic       edge_res,
	input logic       interior,
	input logic       end_of_frame
);

	// A pixel keeps the unit busy for at least the gradient and square cycles.
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_valid && pix_ready) |=> !pix_ready ##1 !pix_ready)
		else $error("pixel taken while the previous one is still in work");

	// A new result appears only at the end of the sequence, while input is held.
	a_result_from_sequence: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> !$past(pix_ready))
		else $error("result appeared without a finished pixel");

	// Border centres carry no magnitude and no edge.
	a_border_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !interior) |-> (magnitude == 8'd0 && !edge_res))
		else $error("border result with nonzero magnitude or edge");

	// A stalled result holds.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(magnitude)
			&& $stable(edge_res) && $stable(interior) && $stable(end_of_frame)))
		else $error("stalled result changed");

endmodule

bind sobel_edge_magnitude_3x3_unit sem_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.pix_valid    (pixel.valid),
	.pix_ready    (pixel.ready),
	.res_valid    (result.valid),
	.res_ready    (result.ready),
	.magnitude    (result.magnitude),
	.edge_res     (result.edge_res),
	.interior     (result.interior),
	.end_of_frame (result.end_of_frame)
);
